@@ rtl/jsd_pkg.sv @@
// ----------------------------------------------------------------------------
// jsd_pkg: shared types and constants of the job sequencing block
// Field widths, default sizes and the job record that travels along the
// sorted insertion chain.
// ----------------------------------------------------------------------------
`default_nettype none

package jsd_pkg;

    localparam int MAX_JOBS_DEF  = 32;
    localparam int MAX_SLOTS_DEF = 32;

    localparam int LABEL_W  = 8;
    localparam int DL_W     = 6;
    localparam int PROFIT_W = 16;
    localparam int TOTAL_W  = 21;
    // One more bit than a deadline, so that a slot limit of 64 fits.
    localparam int LIM_W    = DL_W + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [LABEL_W-1:0]  label;
        logic [DL_W-1:0]     deadline;
        logic [PROFIT_W-1:0] profit;
    } job_t;

    // Per-cycle command to every cell of the chain.
    typedef struct packed {
        logic insert;  // place the arriving job in sorted position
        logic shift;   // move every entry one cell toward the head
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/job_sequencing_deadlines_core.sv @@
// ----------------------------------------------------------------------------
// job_sequencing_deadlines_core: greedy job sequencing with deadlines
// Sorts arriving jobs by profit in a chain of cells, then places them greedily
// into unit time slots and streams out the filled slots with a running total.
// ----------------------------------------------------------------------------
// Loading: one job transfer per cycle while in_ready is high.
// After the job marked last_job: the stored jobs are placed in turn, then the
//   slots are scanned up to the last filled slot; each filled slot is summed,
//   then held until the output takes it. in_ready returns after the final one.
// The placement time is set by the single slot search shared by all jobs, the
//   scan time by the one read port of the slot store.
// Reset (rst_n, asynchronous) clears the job count, chain valid bits, slot
//   used bits and the overflow flag; the slot store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module job_sequencing_deadlines_core
    import jsd_pkg::*;
#(
    parameter int MAX_JOBS  = MAX_JOBS_DEF,
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Job input channel
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [LABEL_W-1:0]  job_label,
    input  wire logic [DL_W-1:0]     deadline,
    input  wire logic [PROFIT_W-1:0] profit,
    input  wire logic                last_job,
    // Slot result channel
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [DL_W-1:0]          slot_index,
    output logic [LABEL_W-1:0]       slot_job,
    output logic [PROFIT_W-1:0]      slot_profit,
    output logic [TOTAL_W-1:0]       running_total,
    output logic                     overflow_seen,
    output logic                     final_result
);

    // Counter wide enough to hold MAX_JOBS itself.
    localparam int CNT_W   = $clog2(MAX_JOBS + 1);
    // Slot address; at least one bit so a single-slot build still has a port.
    localparam int SLOT_IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(MAX_JOBS);
    localparam logic [SLOT_IW-1:0] SLOT_LAST = SLOT_IW'(MAX_SLOTS - 1);
    localparam logic [LIM_W-1:0]   SLOT_LIM  = LIM_W'(MAX_SLOTS);

    // The block loads jobs, places them one per cycle, scans the slots, and
    // for every filled slot updates the running total before presenting it.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PLACE,
        ST_SCAN,
        ST_SUM,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   dropped_reg;
    logic [MAX_SLOTS-1:0]   slot_used_reg;
    logic [SLOT_IW-1:0]     ptr_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   out_valid_reg;
    logic                   final_reg;

    // Slot store: label and profit of the job that owns each slot.
    logic [LABEL_W-1:0]     owner_mem [MAX_SLOTS];
    logic [PROFIT_W-1:0]    pay_mem   [MAX_SLOTS];
    logic [LABEL_W-1:0]     slot_job_reg;
    logic [PROFIT_W-1:0]    slot_profit_reg;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   room;
    cell_ctrl_t             ctrl;
    job_t                   new_job;

    job_t                   cell_job   [MAX_JOBS];
    logic [MAX_JOBS-1:0]    cell_valid;
    logic [MAX_JOBS-1:0]    cell_yield;

    logic [LIM_W-1:0]       place_lim;
    logic                   place_found;
    logic [SLOT_IW-1:0]     place_idx;
    logic [MAX_SLOTS-1:0]   used_above;
    logic                   final_next;
    logic [TOTAL_W:0]       sum_wide;
    logic [LIM_W-1:0]       index_wide;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign room     = (count_reg != CNT_FULL);

    assign new_job.label    = job_label;
    assign new_job.deadline = deadline;
    assign new_job.profit   = profit;

    // An accepted job enters the chain only while there is room; during
    // placement the chain drains toward cell 0, the head being processed.
    assign ctrl.insert = in_xfer && room;
    assign ctrl.shift  = (state_reg == ST_PLACE);

    // ------------------------------------------------------------------
    // Sorted insertion chain
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_JOBS; i++)
    begin : g_cell
        job_t left_job;
        logic left_valid;
        logic left_yield;
        job_t right_job;
        logic right_valid;

        if (i == 0)
        begin : g_head
            assign left_job   = new_job;
            assign left_valid = 1'b0;
            assign left_yield = 1'b0;
        end
        else
        begin : g_mid
            assign left_job   = cell_job[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_yield = cell_yield[i-1];
        end

        if (i == MAX_JOBS - 1)
        begin : g_tail
            assign right_job   = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_body
            assign right_job   = cell_job[i+1];
            assign right_valid = cell_valid[i+1];
        end

        jsd_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_job     (new_job),
            .left_job    (left_job),
            .left_valid  (left_valid),
            .left_yield  (left_yield),
            .right_job   (right_job),
            .right_valid (right_valid),
            .job         (cell_job[i]),
            .valid       (cell_valid[i]),
            .yield       (cell_yield[i])
        );
    end

    // ------------------------------------------------------------------
    // Greedy placement of the head job: the latest free slot at or before
    // its deadline, with deadlines past the last slot clamped to it. A
    // deadline of zero leaves no eligible slot and the job is skipped.
    // ------------------------------------------------------------------
    always_comb
    begin
        place_lim   = ({1'b0, cell_job[0].deadline} > SLOT_LIM) ?
                      SLOT_LIM : {1'b0, cell_job[0].deadline};
        place_found = 1'b0;
        place_idx   = '0;
        for (int j = 0; j < MAX_SLOTS; j++)
        begin
            if (!slot_used_reg[j] && (LIM_W'(j) < place_lim))
            begin
                place_found = 1'b1;
                place_idx   = SLOT_IW'(j);
            end
        end
    end

    // The slot under the scan pointer is the last filled one when no used
    // bit lies above it.
    assign used_above = slot_used_reg >> ptr_reg;
    assign final_next = ((used_above >> 1) == '0);

    // Running total saturates at the largest value of its field.
    assign sum_wide = {1'b0, total_reg} + (TOTAL_W + 1)'(slot_profit_reg);

    // Slot numbers count from 1 and wrap to the field width.
    assign index_wide = LIM_W'(ptr_reg) + LIM_W'(1);

    // ------------------------------------------------------------------
    // Slot store: written during placement, read during the scan.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_PLACE) && cell_valid[0] && place_found)
        begin
            owner_mem[place_idx] <= cell_job[0].label;
            pay_mem[place_idx]   <= cell_job[0].profit;
        end
        if (state_reg == ST_SCAN)
        begin
            slot_job_reg    <= owner_mem[ptr_reg];
            slot_profit_reg <= pay_mem[ptr_reg];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            slot_used_reg <= '0;
            ptr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_xfer)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (last_job)
                        begin
                            state_reg <= ST_PLACE;
                        end
                    end
                end

                ST_PLACE:
                begin
                    if (cell_valid[0] && place_found)
                    begin
                        slot_used_reg[place_idx] <= 1'b1;
                    end
                    count_reg <= count_reg - CNT_W'(1);
                    if (count_reg <= CNT_W'(1))
                    begin
                        count_reg <= '0;
                        ptr_reg   <= '0;
                        total_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    priority if (slot_used_reg[ptr_reg])
                    begin
                        final_reg <= final_next;
                        state_reg <= ST_SUM;
                    end
                    else if (ptr_reg == SLOT_LAST)
                    begin
                        // No slot filled: the set ends without results.
                        slot_used_reg <= '0;
                        dropped_reg   <= 1'b0;
                        state_reg     <= ST_LOAD;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + SLOT_IW'(1);
                    end
                end

                ST_SUM:
                begin
                    total_reg     <= (sum_wide > (TOTAL_W + 1)'(TOTAL_MAX)) ?
                                     TOTAL_MAX : sum_wide[TOTAL_W-1:0];
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (final_reg)
                        begin
                            slot_used_reg <= '0;
                            dropped_reg   <= 1'b0;
                            state_reg     <= ST_LOAD;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg + SLOT_IW'(1);
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == ST_LOAD);
    assign out_valid     = out_valid_reg;
    assign slot_index    = index_wide[DL_W-1:0];
    assign slot_job      = slot_job_reg;
    assign slot_profit   = slot_profit_reg;
    assign running_total = total_reg;
    assign overflow_seen = dropped_reg;
    assign final_result  = final_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !out_valid)
        else $error("job accepted while a result is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("job count beyond store capacity");

    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE && cell_valid[0] && place_found)
            |-> !slot_used_reg[place_idx])
        else $error("placement claimed an occupied slot");

    a_final_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && final_result) |=> (in_ready && slot_used_reg == '0))
        else $error("set not cleared after its final result");

    a_chain_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE && count_reg == CNT_W'(1)) |=> (cell_valid == '0))
        else $error("chain holds jobs after placement");

endmodule

`default_nettype wire

@@ rtl/jsd_cell.sv @@
// ----------------------------------------------------------------------------
// jsd_cell: one cell of the sorted insertion chain
// Holds one job. On insert it either keeps its entry, takes the arriving job,
// or takes its left neighbor's entry; on shift it takes its right neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module jsd_cell
    import jsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire job_t       new_job,
    input  wire job_t       left_job,
    input  wire logic       left_valid,
    input  wire logic       left_yield,
    input  wire job_t       right_job,
    input  wire logic       right_valid,
    output job_t            job,
    output logic            valid,
    output logic            yield
);

    job_t job_reg;
    logic valid_reg;

    // The arriving job goes ahead of this entry when the entry is empty or
    // its profit is not greater. Later arrivals thus win ties.
    assign yield = !valid_reg || (job_reg.profit <= new_job.profit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            priority if (ctrl.shift)
            begin
                valid_reg <= right_valid;
            end
            else if (ctrl.insert && yield)
            begin
                valid_reg <= left_yield ? left_valid : 1'b1;
            end
            else
            begin
                valid_reg <= valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (ctrl.shift)
        begin
            job_reg <= right_job;
        end
        else if (ctrl.insert && yield)
        begin
            job_reg <= left_yield ? left_job : new_job;
        end
        else
        begin
            job_reg <= job_reg;
        end
    end

    assign job   = job_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for job_sequencing_deadlines_core
// Streams sets of jobs into the core. The first sets come from a short table,
// then a few sets fill the job store and run past it, then random sets follow.
// A predictor in the bench keeps its own sorted job list and slot map. It
// works out every slot result, and the results from the core are compared
// with them field by field, in order. Both channels idle at random. The
// receiver also stalls once for a long stretch, so the core stops taking jobs.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jsd_pkg::*;

    localparam int NUM_JOBS    = MAX_JOBS_DEF;
    localparam int NUM_SLOTS   = MAX_SLOTS_DEF;
    localparam int JOB_TARGET  = 310;
    localparam int LONG_STALL  = 400;
    // Placement, slot scan and the sum and emit states of every slot, with margin.
    localparam int DRAIN_WAIT  = 200;

    // One slot result, in port order.
    typedef struct packed {
        logic [DL_W-1:0]     idx;
        logic [LABEL_W-1:0]  job;
        logic [PROFIT_W-1:0] pay;
        logic [TOTAL_W-1:0]  sum;
        logic                ovf;
        logic                fin;
    } slot_res_t;

    // How the results of one job transfer are checked: against the predictor,
    // or against the value written into the opening table.
    typedef enum logic {
        CHK_MODEL,
        CHK_TYPED
    } chk_t;

    typedef struct packed {
        logic [LABEL_W-1:0]  label;
        logic [DL_W-1:0]     dl;
        logic [PROFIT_W-1:0] pr;
        logic                lst;
        chk_t                how;
        logic                has_res;
        slot_res_t           res;
    } row_t;

    localparam int OPENING_LEN = 15;

    // Opening table. Typed rows are those whose outcome is plain: a lone job,
    // a job that can never be placed, a tie on profit where the later job wins.
    localparam row_t OPENING_ROWS [OPENING_LEN] = '{
        // Lone job right after reset, earliest slot.
        '{8'h41, 6'd1,  16'd100,   1'b1, CHK_TYPED, 1'b1,
          '{6'd1,  8'h41, 16'd100,   21'd100,   1'b0, 1'b1}},
        // Deadline zero: never placed, so the set yields nothing.
        '{8'h00, 6'd0,  16'd500,   1'b1, CHK_TYPED, 1'b0, '0},
        // Top label, top profit, last slot.
        '{8'hFF, 6'd32, 16'hFFFF,  1'b1, CHK_TYPED, 1'b1,
          '{6'd32, 8'hFF, 16'hFFFF,  21'd65535, 1'b0, 1'b1}},
        // Deadline past the slot range is clipped to the last slot.
        '{8'h7E, 6'd63, 16'd0,     1'b1, CHK_TYPED, 1'b1,
          '{6'd32, 8'h7E, 16'd0,     21'd0,     1'b0, 1'b1}},
        // Equal profits, same slot: the later arrival takes it.
        '{8'h42, 6'd1,  16'd50,    1'b0, CHK_TYPED, 1'b0, '0},
        '{8'h43, 6'd1,  16'd50,    1'b1, CHK_TYPED, 1'b1,
          '{6'd1,  8'h43, 16'd50,    21'd50,    1'b0, 1'b1}},
        // The textbook five-job example.
        '{8'h61, 6'd2,  16'd100,   1'b0, CHK_MODEL, 1'b0, '0},
        '{8'h62, 6'd1,  16'd19,    1'b0, CHK_MODEL, 1'b0, '0},
        '{8'h63, 6'd2,  16'd27,    1'b0, CHK_MODEL, 1'b0, '0},
        '{8'h64, 6'd1,  16'd25,    1'b0, CHK_MODEL, 1'b0, '0},
        '{8'h65, 6'd3,  16'd15,    1'b1, CHK_MODEL, 1'b0, '0},
        // A mixed set: clipped deadline, deadline zero, zero and top profits.
        '{8'h80, 6'd33, 16'd1234,  1'b0, CHK_MODEL, 1'b0, '0},
        '{8'h01, 6'd0,  16'hFFFF,  1'b0, CHK_MODEL, 1'b0, '0},
        '{8'h02, 6'd2,  16'd0,     1'b0, CHK_MODEL, 1'b0, '0},
        '{8'h03, 6'd2,  16'hFFFF,  1'b1, CHK_MODEL, 1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [LABEL_W-1:0]  job_label;
    logic [DL_W-1:0]     deadline;
    logic [PROFIT_W-1:0] profit;
    logic                last_job;
    logic                out_valid;
    logic                out_ready;
    logic [DL_W-1:0]     slot_index;
    logic [LABEL_W-1:0]  slot_job;
    logic [PROFIT_W-1:0] slot_profit;
    logic [TOTAL_W-1:0]  running_total;
    logic                overflow_seen;
    logic                final_result;

    job_sequencing_deadlines_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .job_label     (job_label),
        .deadline      (deadline),
        .profit        (profit),
        .last_job      (last_job),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .slot_index    (slot_index),
        .slot_job      (slot_job),
        .slot_profit   (slot_profit),
        .running_total (running_total),
        .overflow_seen (overflow_seen),
        .final_result  (final_result)
    );

    // Free-running clock, 8 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: the sorted job list and the drop flag of the set.
    // ------------------------------------------------------------------------
    job_t      job_book [NUM_JOBS];
    int        book_count;
    logic      book_dropped;

    slot_res_t fresh_slots [$];    // results of the most recent job transfer
    slot_res_t slot_expect [$];    // results still owed by the core
    row_t      row_notes [$];      // check mode of each offered job, in order

    int errors;
    int jobs_sent;
    int jobs_taken;
    int results_checked;
    int sets_seen;
    int sets_overflowed;
    int sets_blank;
    int hold_asks;
    int hold_served;

    // Takes one job transfer: files the job in profit order, or drops it when
    // the list is full. On the last job of a set it places every stored job in
    // the latest free slot at or before its deadline and lists the filled slots.
    function automatic void absorb_job(logic [LABEL_W-1:0] lb, logic [DL_W-1:0] dl,
                                       logic [PROFIT_W-1:0] pr, logic lst);
        int                  pos;
        int                  s;
        int                  last_fill;
        logic [TOTAL_W:0]    acc;
        bit [NUM_SLOTS-1:0]  taken;
        logic [LABEL_W-1:0]  owner [NUM_SLOTS];
        logic [PROFIT_W-1:0] pay [NUM_SLOTS];
        slot_res_t           r;

        fresh_slots.delete();
        if (book_count >= NUM_JOBS)
            book_dropped = 1'b1;
        else
        begin
            // A new job goes ahead of the first entry whose profit is not
            // greater, so among equal profits the newest comes first.
            pos = 0;
            while (pos < book_count && job_book[pos].profit > pr)
                pos++;
            for (int k = book_count; k > pos; k--)
                job_book[k] = job_book[k - 1];
            job_book[pos] = '{label: lb, deadline: dl, profit: pr};
            book_count++;
        end
        if (!lst)
            return;

        taken = '0;
        for (int i = 0; i < book_count; i++)
        begin
            s = job_book[i].deadline;
            if (s > NUM_SLOTS)
                s = NUM_SLOTS;
            while (s > 0)
            begin
                if (!taken[s - 1])
                begin
                    taken[s - 1] = 1'b1;
                    owner[s - 1] = job_book[i].label;
                    pay[s - 1]   = job_book[i].profit;
                    break;
                end
                s--;
            end
        end

        last_fill = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (taken[i])
                last_fill = i + 1;

        acc = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (taken[i])
            begin
                acc = acc + pay[i];
                if (acc > TOTAL_MAX)
                    acc = TOTAL_MAX;
                r.idx = DL_W'(i + 1);
                r.job = owner[i];
                r.pay = pay[i];
                r.sum = acc[TOTAL_W-1:0];
                r.ovf = book_dropped;
                r.fin = (i + 1 == last_fill);
                fresh_slots.push_back(r);
            end
        end

        sets_seen++;
        if (book_dropped)
            sets_overflowed++;
        if (fresh_slots.size() == 0)
            sets_blank++;
        book_count   = 0;
        book_dropped = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge; the bench only
    // changes inputs at the falling edge, so the samples are settled.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        row_t      nt;
        slot_res_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                nt = row_notes.pop_front();
                absorb_job(job_label, deadline, profit, last_job);
                jobs_taken++;
                if (nt.how == CHK_TYPED)
                begin
                    if (nt.has_res)
                        slot_expect.push_back(nt.res);
                end
                else
                begin
                    foreach (fresh_slots[i])
                        slot_expect.push_back(fresh_slots[i]);
                end
            end
            if (out_valid && out_ready)
            begin
                if (slot_expect.size() == 0)
                begin
                    $error("slot result with none expected: slot %0d, job %0d",
                           slot_index, slot_job);
                    errors++;
                end
                else
                begin
                    want = slot_expect.pop_front();
                    check_field("slot_index",    want.idx, slot_index);
                    check_field("slot_job",      want.job, slot_job);
                    check_field("slot_profit",   want.pay, slot_profit);
                    check_field("running_total", want.sum, running_total);
                    check_field("overflow_seen", want.ovf, overflow_seen);
                    check_field("final_result",  want.fin, final_result);
                    results_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Mostly ready, with short random stalls and the odd long one.
    // Every so often it switches into a calm stretch with no stalls at all.
    // A request from the sender starts one very long stall, so the core backs
    // up and stops taking jobs.
    // ------------------------------------------------------------------------
    initial
    begin
        int  stall_left;
        int  cyc;
        int  roll;
        bit  calm;
        stall_left = 0;
        cyc        = 0;
        calm       = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 128 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                stall_left  = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                roll = $urandom_range(0, 99);
                if (!calm && roll < 20)
                    stall_left = $urandom_range(1, 3);
                else if (!calm && roll < 23)
                    stall_left = $urandom_range(8, 40);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers.
    // ------------------------------------------------------------------------
    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // Deadlines mostly crowd into a narrow range so that jobs compete for
    // slots; some are zero and some lie past the slot range.
    function automatic logic [DL_W-1:0] pick_deadline(int set_size);
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = set_size / 2 + 2;
        if (top > NUM_SLOTS)
            top = NUM_SLOTS;
        if (roll < 78)
            return DL_W'($urandom_range(1, top));
        else if (roll < 88)
            return DL_W'($urandom_range(1, NUM_SLOTS));
        else if (roll < 94)
            return '0;
        else
            return DL_W'($urandom_range(NUM_SLOTS + 1, 63));
    endfunction

    // A share of profits comes from a few fixed values, so ties are common.
    function automatic logic [PROFIT_W-1:0] pick_profit();
        if ($urandom_range(0, 99) < 70)
            return PROFIT_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'd777;
            default: return '1;
        endcase
    endfunction

    // Offers one job after a gap of idle cycles and holds it until transfer.
    // With no gap the next job follows at once, so valid stays high.
    task automatic send_job(row_t nt, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        row_notes.push_back(nt);
        in_valid  <= 1'b1;
        job_label <= nt.label;
        deadline  <= nt.dl;
        profit    <= nt.pr;
        last_job  <= nt.lst;
        jobs_sent++;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // Drops valid and waits until the core has delivered everything owed.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (slot_expect.size() != 0)
            @(negedge clk);
    endtask

    // One set of random jobs; the last one carries last_job.
    task automatic play_set(int set_size, bit no_deadline);
        row_t nt;
        bit   calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < set_size; k++)
        begin
            nt       = '0;
            nt.how   = CHK_MODEL;
            nt.label = LABEL_W'($urandom_range(0, 255));
            nt.dl    = no_deadline ? '0 : pick_deadline(set_size);
            nt.pr    = pick_profit();
            nt.lst   = (k == set_size - 1);
            send_job(nt, pick_gap(calm));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int roll;
        int set_size;
        int random_sets;
        errors          = 0;
        jobs_sent       = 0;
        jobs_taken      = 0;
        results_checked = 0;
        sets_seen       = 0;
        sets_overflowed = 0;
        sets_blank      = 0;
        hold_asks       = 0;
        hold_served     = 0;
        book_count      = 0;
        book_dropped    = 1'b0;
        random_sets     = 0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        job_label       = '0;
        deadline        = '0;
        profit          = '0;
        last_job        = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Opening table.
        for (int i = 0; i < OPENING_LEN; i++)
            send_job(OPENING_ROWS[i], pick_gap(1'b0));

        // The sender waits here until every slot of the opening sets is out.
        wait_drained();

        // A full store while the receiver holds off: the core fills, then
        // stalls its input while the next set is already on offer.
        hold_asks++;
        play_set(NUM_JOBS, 1'b0);
        // One past capacity: the last job itself is dropped.
        play_set(NUM_JOBS + 1, 1'b0);
        // Past capacity with nothing placeable: no results, flag unseen.
        play_set(NUM_JOBS + 3, 1'b1);
        // Past capacity with placeable jobs, so the flag shows on results.
        play_set(NUM_JOBS + 2, 1'b0);

        // Random sets, mostly small, a few near or past capacity.
        while (jobs_sent < JOB_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                set_size = $urandom_range(1, 8);
            else if (roll < 88)
                set_size = $urandom_range(9, 20);
            else if (roll < 96)
                set_size = $urandom_range(NUM_JOBS - 4, NUM_JOBS);
            else
                set_size = $urandom_range(NUM_JOBS + 1, NUM_JOBS + 4);
            play_set(set_size, 1'b0);
            random_sets++;
            if (random_sets % 8 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Ran %0d job transfers in %0d sets; %0d slot results checked.",
                 jobs_taken, sets_seen, results_checked);
        $display("%0d sets overran the job store, %0d sets filled no slot.",
                 sets_overflowed, sets_blank);
        if (errors == 0)
            $display("job_sequencing_deadlines_core: match");
        else
            $display("job_sequencing_deadlines_core: mismatch");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #3ms;
        $display("Timed out with %0d slot results still owed.", slot_expect.size());
        $display("job_sequencing_deadlines_core: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
rtl/jsd_pkg.sv
rtl/jsd_cell.sv
rtl/job_sequencing_deadlines_core.sv
tb/sv/testbench.sv
